// ===== rtl/dcpma_pkg.sv =====
// shared types and constants for the dual-channel pressure moving average
package dcpma_pkg;

   // pressure sample width after the status bits are dropped
   localparam int PRESS_W = 14;

   // sensor frame byte masks
   localparam logic [7:0] STATUS_MASK   = 8'b1100_0000;
   localparam logic [7:0] PRESS_HI_MASK = 8'b0011_1111;

   // request kinds carried on tuser
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   // register select bit of the csr address (byte address 4 * index)
   localparam logic REG_ENABLE = 1'b0;

   // one ring entry for each of the two channels
   typedef logic [1:0][PRESS_W-1:0] press_pair_type;

   // control broadcast to every cell of the ring
   typedef struct packed {
      logic shift;
      logic chan;
      logic clear;
   } cell_ctrl_type;

endpackage

// ===== rtl/dcpma_cell.sv =====
// one ring cell: holds a sample of each channel and passes it down the row
module dcpma_cell
   import dcpma_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctrl_type  ctrl,
   input  press_pair_type data_in,
   output press_pair_type data_out
);

   press_pair_type entry_ff;
   press_pair_type entry_in;

   // clear wins, otherwise shift the selected channel's lane
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in = '0;
      end else if (ctrl.shift) begin
         entry_in[ctrl.chan] = data_in[ctrl.chan];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign data_out = entry_ff;

endmodule

// ===== rtl/dual_channel_pressure_moving_average.sv =====
// top level: sample ring of cells, running sums and average output stage
//
//   channel  | direction | handshake          | payload
//   req_     | in        | tvalid / tready    | tdata: high_byte, low_byte; tuser: action
//   rsp_     | out       | tvalid / tready    | tdata: print/refuel averages; tuser: flags
//   csr_     | in/out    | psel/penable/pready| enable register at byte address 0
//
// one request per cycle while responses are taken; each request gives one response,
// registered after the ring shift and sum update, then the reciprocal multiply for the average
// a stalled response holds the average stage, and the request side stalls behind it
// synchronous active-high reset empties the ring, sums, averages and both stages
module dual_channel_pressure_moving_average
   import dcpma_pkg::*;
#(
   parameter int WINDOW_LEN = 8
)
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] high_byte, [15:8] low_byte
   input  logic        req_tuser,   // [0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [13:0] print_average, [27:14] refuel_average, rest zero
   output logic [1:0]  rsp_tuser,   // [0] updated_channel, [1] accepted
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SUM_W       = PRESS_W + $clog2(WINDOW_LEN);
   localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W     = SUM_W + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

   // configuration
   logic enable_ff, enable_in;
   logic csr_write;

   // request fields
   logic               req_action;
   logic [7:0]         req_high_byte;
   logic [7:0]         req_low_byte;
   logic [PRESS_W-1:0] sample;
   logic               req_accept;
   logic               do_sample;
   logic               do_clear;

   // ring and sums
   cell_ctrl_type      ctrl;
   press_pair_type     chain [WINDOW_LEN+1];
   logic [PRESS_W-1:0] oldest;
   logic [SUM_W-1:0]   sum_ff [2];
   logic [SUM_W-1:0]   sum_in [2];
   logic               active_ff, active_in;

   // sum stage
   logic a_vld_ff, a_vld_in;
   logic a_chan_ff, a_chan_in;
   logic a_took_ff, a_took_in;
   logic a_clear_ff, a_clear_in;

   // average stage
   logic               b_load;
   logic [PROD_W-1:0]  product;
   logic [PRESS_W-1:0] quot;
   logic [PRESS_W-1:0] avg_ff [2];
   logic [PRESS_W-1:0] avg_in [2];

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PRESS_W-1:0] rsp_print_ff, rsp_print_in;
   logic [PRESS_W-1:0] rsp_refuel_ff, rsp_refuel_in;
   logic               rsp_chan_ff, rsp_chan_in;
   logic               rsp_took_ff, rsp_took_in;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ENABLE) ? {31'd0, enable_ff} : 32'd0;

   always_comb begin
      enable_in = enable_ff;
      if (csr_write && csr_paddr[2] == REG_ENABLE) begin
         enable_in = csr_pwdata[0];
      end
   end

   // request decode
   assign req_action    = req_tuser;
   assign req_high_byte = req_tdata[7:0];
   assign req_low_byte  = req_tdata[15:8];
   assign sample        = {req_high_byte[5:0] & PRESS_HI_MASK[5:0], req_low_byte};
   assign req_tready    = !a_vld_ff || b_load;
   assign req_accept    = req_tvalid && req_tready;
   assign do_clear      = req_accept && (req_action == ACTION_CLEAR);
   assign do_sample     = req_accept && (req_action == ACTION_SAMPLE) && enable_ff;

   // ring of cells, newest sample enters cell 0
   assign ctrl.shift = do_sample;
   assign ctrl.chan  = active_ff;
   assign ctrl.clear = do_clear;
   assign chain[0]   = {sample, sample};

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      dcpma_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .data_in  (chain[i]),
         .data_out (chain[i+1])
      );
   end

   assign oldest = chain[WINDOW_LEN][active_ff];

   // running sums and channel toggle
   always_comb begin
      sum_in[0] = sum_ff[0];
      sum_in[1] = sum_ff[1];
      active_in = active_ff;
      if (do_clear) begin
         sum_in[0] = '0;
         sum_in[1] = '0;
      end else if (do_sample) begin
         sum_in[active_ff] = sum_ff[active_ff] - SUM_W'(oldest) + SUM_W'(sample);
         active_in         = !active_ff;
      end
   end

   // sum stage hand-off
   always_comb begin
      a_vld_in   = a_vld_ff;
      a_chan_in  = a_chan_ff;
      a_took_in  = a_took_ff;
      a_clear_in = a_clear_ff;
      if (req_accept) begin
         a_vld_in   = 1'b1;
         a_chan_in  = do_sample ? active_ff : 1'b0;
         a_took_in  = do_sample;
         a_clear_in = do_clear;
      end else if (b_load) begin
         a_vld_in = 1'b0;
      end
   end

   // average by reciprocal multiply, exact for every sum in range
   assign b_load  = a_vld_ff && (!rsp_valid_ff || rsp_tready);
   assign product = PROD_W'(sum_ff[a_chan_ff]) * PROD_W'(RECIP);
   assign quot    = product[RECIP_SHIFT +: PRESS_W];

   always_comb begin
      avg_in[0] = avg_ff[0];
      avg_in[1] = avg_ff[1];
      if (b_load) begin
         if (a_clear_ff) begin
            avg_in[0] = '0;
            avg_in[1] = '0;
         end else if (a_took_ff) begin
            avg_in[a_chan_ff] = quot;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_print_in  = rsp_print_ff;
      rsp_refuel_in = rsp_refuel_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_took_in   = rsp_took_ff;
      if (b_load) begin
         rsp_valid_in  = 1'b1;
         rsp_print_in  = avg_in[0];
         rsp_refuel_in = avg_in[1];
         rsp_chan_in   = a_chan_ff;
         rsp_took_in   = a_took_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         active_ff    <= 1'b0;
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         avg_ff[0]    <= '0;
         avg_ff[1]    <= '0;
         a_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         active_ff    <= active_in;
         sum_ff[0]    <= sum_in[0];
         sum_ff[1]    <= sum_in[1];
         avg_ff[0]    <= avg_in[0];
         avg_ff[1]    <= avg_in[1];
         a_vld_ff     <= a_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_chan_ff     <= a_chan_in;
      a_took_ff     <= a_took_in;
      a_clear_ff    <= a_clear_in;
      rsp_print_ff  <= rsp_print_in;
      rsp_refuel_ff <= rsp_refuel_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_took_ff   <= rsp_took_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_refuel_ff, rsp_print_ff};
   assign rsp_tuser  = {rsp_took_ff, rsp_chan_ff};

endmodule
